@@ hw/rtl/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg
// shared widths, types and constants of the ray versus box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int CW     = 32;                          // coordinate width
  localparam int FB     = 16;                          // fraction bits
  localparam int TW     = 48;                          // slab parameter width
  localparam int QW     = CW + FB;                     // quotient width
  localparam int SW     = ((QW > TW) ? QW : TW) + 1;   // saturation compare width
  localparam int NL     = 6;                           // divider lanes
  localparam int NA     = 3;                           // axes
  localparam int CFG_AW = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   diff_t;
  typedef logic [CW-1:0]        mag_t;
  typedef logic [QW-1:0]        quot_t;
  typedef logic signed [TW-1:0] tpar_t;

  localparam tpar_t T_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam tpar_t T_MIN = {1'b1, {(TW-1){1'b0}}};

  typedef enum logic [CFG_AW-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_HEADING_X = 3'd3,
    REG_HEADING_Y = 3'd4,
    REG_HEADING_Z = 3'd5
  } reg_idx_t;

  // per item flags that ride alongside the divider lanes
  typedef struct packed {
    logic [NL-1:0] neg;    // quotient sign per lane
    logic [NA-1:0] flat;   // zero heading, origin between the planes
    logic [NA-1:0] empty;  // zero heading, origin outside the planes
  } side_t;

endpackage

@@ hw/rtl/rbst_if.sv @@
// ----------------------------------------------------------------------------
// rbst_in_if / rbst_out_if
// valid/ready channels for boxes in and slab test results out
// ----------------------------------------------------------------------------
interface rbst_in_if;
  import rbst_pkg::*;
  logic   valid;
  logic   ready;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;
  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z,
                box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface rbst_out_if;
  import rbst_pkg::*;
  logic  valid;
  logic  ready;
  logic  hit;
  tpar_t t_enter;
  tpar_t t_exit;
  modport source (output valid, hit, t_enter, t_exit, input ready);
  modport sink (input valid, hit, t_enter, t_exit, output ready);
endinterface

@@ hw/rtl/rbst_div.sv @@
// ----------------------------------------------------------------------------
// rbst_div
// six lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rbst_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  rbst_pkg::mag_t   in_num [rbst_pkg::NL],
  input  rbst_pkg::mag_t   in_den [rbst_pkg::NL],
  input  rbst_pkg::side_t  in_side,
  output logic             out_valid,
  output rbst_pkg::quot_t  out_quot [rbst_pkg::NL],
  output rbst_pkg::side_t  out_side
);
  import rbst_pkg::*;

  // stage k holds the state after k quotient bits
  mag_t  rem_r  [QW+1][NL];
  quot_t word_r [QW+1][NL];
  mag_t  den_r  [QW+1][NL];
  side_t side_r [QW+1];
  logic  vld_r  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int l = 0; l < NL; l++) begin
        rem_r[0][l]  <= '0;
        word_r[0][l] <= {in_num[l], {FB{1'b0}}};
        den_r[0][l]  <= in_den[l];
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW:0] trial [NL];
    logic        ge    [NL];
    logic [CW:0] diff  [NL];

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        trial[l] = {rem_r[k][l], word_r[k][l][QW-1]};
        ge[l]    = trial[l] >= {1'b0, den_r[k][l]};
        diff[l]  = trial[l] - {1'b0, den_r[k][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        for (int l = 0; l < NL; l++) begin
          rem_r[k+1][l]  <= ge[l] ? diff[l][CW-1:0] : trial[l][CW-1:0];
          word_r[k+1][l] <= {word_r[k][l][QW-2:0], ge[l]};
          den_r[k+1][l]  <= den_r[k][l];
        end
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_side  = side_r[QW];
  always_comb begin
    for (int l = 0; l < NL; l++) out_quot[l] = word_r[QW][l];
  end

endmodule

@@ hw/rtl/ray_box_slab_test.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test
// ray versus axis-aligned box slab test in fixed point, one box per clock
// ----------------------------------------------------------------------------
// a box passes stage 0, the divider, p1, p2, p3 and the p4 output register
// throughput: one box per cycle, set by the fully pipelined bit-per-stage divider
// a stalled output freezes the whole pipeline, nothing is dropped
// synchronous active-low reset clears valid bits and loads the default ray
// ----------------------------------------------------------------------------
module ray_box_slab_test (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rbst_pkg::CFG_AW-1:0]  cfg_addr,
  input  rbst_pkg::coord_t             cfg_data,
  rbst_in_if.sink                      in_box,
  rbst_out_if.source                   out_res
);
  import rbst_pkg::*;

  coord_t origin_r  [NA];
  coord_t heading_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0]  <= '0;
      origin_r[1]  <= '0;
      origin_r[2]  <= '0;
      heading_r[0] <= coord_t'(1) <<< FB;
      heading_r[1] <= '0;
      heading_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORIGIN_X:  origin_r[0]  <= cfg_data;
        REG_ORIGIN_Y:  origin_r[1]  <= cfg_data;
        REG_ORIGIN_Z:  origin_r[2]  <= cfg_data;
        REG_HEADING_X: heading_r[0] <= cfg_data;
        REG_HEADING_Y: heading_r[1] <= cfg_data;
        REG_HEADING_Z: heading_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en           = !out_valid_r || out_res.ready;
  assign in_box.ready = en;

  // stage 0: corner minus origin, lanes 0..2 min corner, 3..5 max corner
  coord_t box [NL];
  diff_t  diff_r [NL];
  logic   s0_vld_r;

  assign box[0] = in_box.box_min_x;
  assign box[1] = in_box.box_min_y;
  assign box[2] = in_box.box_min_z;
  assign box[3] = in_box.box_max_x;
  assign box[4] = in_box.box_max_y;
  assign box[5] = in_box.box_max_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_box.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        diff_r[l] <= diff_t'(box[l]) - diff_t'(origin_r[l % NA]);
      end
    end
  end

  // magnitudes and signs for the divider
  mag_t  num   [NL];
  mag_t  den   [NL];
  side_t side;

  always_comb begin
    diff_t neg_d;
    diff_t neg_h;
    logic  out_pl;
    for (int l = 0; l < NL; l++) begin
      neg_d       = -diff_r[l];
      neg_h       = -diff_t'(heading_r[l % NA]);
      num[l]      = diff_r[l][CW] ? neg_d[CW-1:0] : diff_r[l][CW-1:0];
      den[l]      = heading_r[l % NA][CW-1] ? neg_h[CW-1:0] : heading_r[l % NA];
      side.neg[l] = diff_r[l][CW] ^ heading_r[l % NA][CW-1];
    end
    for (int a = 0; a < NA; a++) begin
      // origin strictly beyond both planes on the same side
      out_pl = (diff_r[a] > 0 && diff_r[a+NA] > 0) || (diff_r[a] < 0 && diff_r[a+NA] < 0);
      side.flat[a]  = (heading_r[a] == '0) && !out_pl;
      side.empty[a] = (heading_r[a] == '0) && out_pl;
    end
  end

  logic  dv_vld;
  quot_t dv_quot [NL];
  side_t dv_side;

  rbst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_vld_r),
    .in_num    (num),
    .in_den    (den),
    .in_side   (side),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // p1: sign and saturate, flat axes take the full parameter range
  localparam logic [SW-1:0] LIM_POS = SW'(T_MAX);
  localparam logic [SW-1:0] LIM_NEG = LIM_POS + SW'(1);

  tpar_t         tp_nxt [NL];
  tpar_t         tp_r   [NL];
  logic [NA-1:0] p1_empty_r;
  logic          p1_vld_r;

  always_comb begin
    logic [SW-1:0] qx;
    for (int l = 0; l < NL; l++) begin
      qx = SW'(dv_quot[l]);
      if (dv_side.flat[l % NA]) begin
        tp_nxt[l] = (l < NA) ? T_MIN : T_MAX;
      end else if (dv_side.neg[l]) begin
        tp_nxt[l] = (qx >= LIM_NEG) ? T_MIN : -tpar_t'(qx[TW-1:0]);
      end else begin
        tp_nxt[l] = (qx > LIM_POS) ? T_MAX : tpar_t'(qx[TW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r       <= tp_nxt;
      p1_empty_r <= dv_side.empty;
    end
  end

  // p2: order each slab pair
  tpar_t lo_r [NA];
  tpar_t hi_r [NA];
  logic  p2_miss_r;
  logic  p2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_miss_r <= |p1_empty_r;
      for (int a = 0; a < NA; a++) begin
        lo_r[a] <= (tp_r[a] > tp_r[a+NA]) ? tp_r[a+NA] : tp_r[a];
        hi_r[a] <= (tp_r[a] > tp_r[a+NA]) ? tp_r[a] : tp_r[a+NA];
      end
    end
  end

  // p3: intersect x with y
  tpar_t p3_enter_r;
  tpar_t p3_leave_r;
  tpar_t p3_lo_z_r;
  tpar_t p3_hi_z_r;
  logic  p3_miss_r;
  logic  p3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_miss_r  <= p2_miss_r || (lo_r[0] > hi_r[1]) || (lo_r[1] > hi_r[0]);
      p3_enter_r <= (lo_r[1] > lo_r[0]) ? lo_r[1] : lo_r[0];
      p3_leave_r <= (hi_r[1] < hi_r[0]) ? hi_r[1] : hi_r[0];
      p3_lo_z_r  <= lo_r[2];
      p3_hi_z_r  <= hi_r[2];
    end
  end

  // p4: intersect with z, output register
  logic  miss_z;
  logic  hit_r;
  tpar_t t_enter_r;
  tpar_t t_exit_r;

  assign miss_z = p3_miss_r || (p3_enter_r > p3_hi_z_r) || (p3_lo_z_r > p3_leave_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= !miss_z;
      if (miss_z) begin
        t_enter_r <= '0;
        t_exit_r  <= '0;
      end else begin
        t_enter_r <= (p3_lo_z_r > p3_enter_r) ? p3_lo_z_r : p3_enter_r;
        t_exit_r  <= (p3_hi_z_r < p3_leave_r) ? p3_hi_z_r : p3_leave_r;
      end
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.hit     = hit_r;
  assign out_res.t_enter = t_enter_r;
  assign out_res.t_exit  = t_exit_r;

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_r |-> t_enter_r == '0 && t_exit_r == '0)
    else $error("miss result carries nonzero parameters");

  a_hit_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> t_enter_r <= t_exit_r)
    else $error("hit with entry after exit");

  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p3_vld_r) && $stable(dv_vld) && $stable(s0_vld_r))
    else $error("pipeline moved during stall");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !p3_vld_r)
    else $error("valid bits survive reset");

endmodule
